### rtl/sdr_pkg.sv
`default_nettype none
package sdr_pkg;

  localparam int unsigned SDR_STORE_DEPTH = 128;
  localparam int unsigned SDR_VALUE_W     = 32;
  localparam int unsigned SDR_OUT_DATA_W  = 40;

  // word travelling down the cell chain
  typedef struct packed {
    logic                   vld;
    logic [SDR_VALUE_W-1:0] value;
    logic                   last;
    logic                   hit;     // matched a stored value upstream
    logic                   placed;  // found a free slot upstream
  } sdr_tok_t;

endpackage
`default_nettype wire

### rtl/stream_duplicate_remover_top.sv
// Duplicate remover for sets of signed 32-bit values.
// Input stream: in_tdata carries one value per word, in_tlast marks the last
//   word of a set. Output stream: one word per input word, same order;
//   out_tdata holds the value, a keep bit, the any-repeat flag and the
//   store-overflow flag; out_tlast repeats the end-of-set mark.
// Each word walks a chain of STORE_DEPTH compare cells, one cell per cycle unless stalled.
//   Each cell holds one distinct value of the current set; a new value is
//   parked in the first free cell it passes. The last word of a set clears
//   every cell behind it, so the next set can follow directly.
// Path: each word is registered in every cell, then in the output register.
// Throughput: one word per cycle unless stalled; the chain is a pure shift pipeline, words
//   of the same set follow each other cell by cell and see earlier stores.
// Distinct values beyond STORE_DEPTH are kept but not stored; the overflow
//   flag then stays high until the end of the set.
// Stall: when out_tvalid is high and out_tready low, the whole chain holds
//   and in_tready drops; in_tready = !out_tvalid || out_tready.
// Reset (synchronous, rst_n low): chain emptied, all cells free, flags clear.
`default_nettype none
module stream_duplicate_remover_top
  import sdr_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = SDR_STORE_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [SDR_VALUE_W-1:0]    in_tdata,   // [31:0] sample_value
  input  wire logic                      in_tlast,   // end_of_set
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [SDR_OUT_DATA_W-1:0]      out_tdata,  // [31:0] echo_value, [32] keep,
                                                     // [33] any_repeat,
                                                     // [34] store_overflow, rest zero
  output logic                           out_tlast   // set_done
);

  logic     adv;
  sdr_tok_t chain [STORE_DEPTH+1];

  // whole pipeline moves when the output register is free or being drained
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  assign chain[0] = '{vld: in_tvalid, value: in_tdata, last: in_tlast,
                      hit: 1'b0, placed: 1'b0};

  for (genvar gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
    sdr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .tok_in  (chain[gi]),
      .tok_out (chain[gi+1])
    );
  end

  sdr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .tok_in     (chain[STORE_DEPTH]),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

### rtl/sdr_cell.sv
`default_nettype none
module sdr_cell
  import sdr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv,
  input  wire sdr_tok_t tok_in,
  output sdr_tok_t      tok_out
);

  sdr_tok_t               tok_r, tok_nxt;
  logic                   slot_vld_r, slot_vld_nxt;
  logic [SDR_VALUE_W-1:0] slot_val_r, slot_val_nxt;
  logic                   hit_here;
  logic                   claim;

  assign hit_here = slot_vld_r && (slot_val_r == tok_in.value);
  // slots fill in order, so the first free slot is the next one to take
  assign claim    = tok_in.vld && !slot_vld_r && !tok_in.hit && !tok_in.placed;

  always_comb begin
    tok_nxt        = tok_in;
    tok_nxt.hit    = tok_in.hit | (tok_in.vld & hit_here);
    tok_nxt.placed = tok_in.placed | claim;
    slot_vld_nxt   = slot_vld_r;
    slot_val_nxt   = slot_val_r;
    if (tok_in.vld && tok_in.last) begin
      // end of set sweeps the chain right behind the last word
      slot_vld_nxt = 1'b0;
    end else if (claim) begin
      slot_vld_nxt = 1'b1;
      slot_val_nxt = tok_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r      <= '0;
      slot_vld_r <= 1'b0;
    end else if (adv) begin
      tok_r      <= tok_nxt;
      slot_vld_r <= slot_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      slot_val_r <= slot_val_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

### rtl/sdr_out_stage.sv
`default_nettype none
module sdr_out_stage
  import sdr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire sdr_tok_t                  tok_in,
  output logic                           out_tvalid,
  output logic [SDR_OUT_DATA_W-1:0]      out_tdata,
  output logic                           out_tlast
);

  logic                      rep_r, rep_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      vld_r;
  logic [SDR_OUT_DATA_W-1:0] data_r, data_nxt;
  logic                      last_r;
  logic                      rep_now, ovf_now;

  assign rep_now = rep_r | tok_in.hit;
  assign ovf_now = ovf_r | (!tok_in.hit && !tok_in.placed);

  always_comb begin
    data_nxt = {{(SDR_OUT_DATA_W-SDR_VALUE_W-3){1'b0}},
                ovf_now, rep_now, !tok_in.hit, tok_in.value};
    rep_nxt  = rep_r;
    ovf_nxt  = ovf_r;
    if (tok_in.vld) begin
      rep_nxt = tok_in.last ? 1'b0 : rep_now;
      ovf_nxt = tok_in.last ? 1'b0 : ovf_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      rep_r <= 1'b0;
      ovf_r <= 1'b0;
    end else if (adv) begin
      vld_r <= tok_in.vld;
      rep_r <= rep_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_in.vld) begin
      data_r <= data_nxt;
      last_r <= tok_in.last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

### rtl/sdr_checker.sv
`default_nettype none
module sdr_checker
  import sdr_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_tready,
  input wire logic                      out_tvalid,
  input wire logic                      out_tready,
  input wire logic [SDR_OUT_DATA_W-1:0] out_tdata,
  input wire logic                      out_tlast
);

  // stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed under stall");

  // a dropped word means a repeat was seen in this set
  a_drop_rep: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[32] |-> out_tdata[33])
    else $error("drop without repeat flag");

  // input side only waits on a stalled output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input stalled without output backpressure");

  // flags start clean after end of set when next word has no repeat
  a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast ##1 out_tvalid && out_tdata[32]
      |-> !out_tdata[33])
    else $error("repeat flag leaked across sets");

endmodule

bind stream_duplicate_remover_top sdr_checker u_sdr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

### tb/stream_duplicate_remover_top_tb.sv
`timescale 1ns / 1ps

module stream_duplicate_remover_top_tb;
  import sdr_pkg::*;

  localparam int RANDOM_WORDS   = 1500;
  localparam int MAX_GAP        = 18;
  localparam int HOLD_CYCLES    = 400;                  // long receiver hold-off
  localparam int TAIL_CYCLES    = SDR_STORE_DEPTH + 16; // margin over the chain depth
  localparam int WATCHDOG_LIMIT = 4000;                 // cycles without any word moving

  // set kinds for the random part
  localparam int KIND_SHORT    = 0;
  localparam int KIND_SINGLE   = 1;
  localparam int KIND_FULL     = 2;  // exactly STORE_DEPTH distinct values
  localparam int KIND_OVERFLOW = 3;  // more distinct values than the store holds

  // one result word as the predictor sees it
  typedef struct packed {
    logic [SDR_VALUE_W-1:0] value;
    logic                   keep;
    logic                   any_repeat;
    logic                   store_overflow;
    logic                   set_done;
  } dedup_word_t;

  // directed row: typed = 1 means the flags below are the expected ones,
  // otherwise the predictor supplies the expectation
  typedef struct packed {
    logic [SDR_VALUE_W-1:0] value;
    logic                   last;
    logic                   typed;
    logic                   keep;
    logic                   any_repeat;
    logic                   store_overflow;
  } dir_row_t;

  localparam int DIR_ROWS = 19;
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    // single-item set right after reset: kept, no repeat
    '{32'h8000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    // fresh set: first copy kept, second copy dropped and flags the repeat
    '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    // repeat on the last word of the set
    '{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    // store cleared: value seen in the previous set is new again
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    // set with no repeat at all
    '{32'h0000_0001, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0},
    '{32'h0000_0002, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0003, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}
  };

  logic                      clk;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [SDR_VALUE_W-1:0]    in_tdata   = '0;  // [31:0] sample_value
  logic                      in_tlast   = 1'b0; // end_of_set
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [SDR_OUT_DATA_W-1:0] out_tdata;        // [31:0] echo_value, [32] keep,
                                               // [33] any_repeat, [34] store_overflow
  logic                      out_tlast;        // set_done

  stream_duplicate_remover_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // predictor state: distinct values of the current set plus sticky flags
  logic [SDR_VALUE_W-1:0] seen_store [SDR_STORE_DEPTH];
  int                     seen_cnt      = 0;
  bit                     repeat_seen   = 1'b0;
  bit                     overflow_seen = 1'b0;

  dedup_word_t pending_words[$];  // expected output words, oldest first

  int  mismatch_count  = 0;
  int  words_sent      = 0;
  int  words_checked   = 0;
  int  drops_seen      = 0;
  int  sets_seen       = 0;
  int  sets_repeat     = 0;
  int  sets_overflow   = 0;
  int  idle_cycles     = 0;
  bit  in_no_idle      = 1'b0;
  bit  out_no_idle     = 1'b0;
  bit  hold_request    = 1'b0;
  int  holds_done      = 0;

  // clock: 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // keep/drop decision for one word; updates the predictor state
  function automatic dedup_word_t dedup_predict(logic [SDR_VALUE_W-1:0] v, bit last);
    dedup_word_t w;
    bit          found;
    found = 1'b0;
    for (int i = 0; i < seen_cnt; i++)
      if (seen_store[i] == v) found = 1'b1;
    if (found) begin
      w.keep      = 1'b0;
      repeat_seen = 1'b1;
    end else begin
      w.keep = 1'b1;
      if (seen_cnt < SDR_STORE_DEPTH) begin
        seen_store[seen_cnt] = v;
        seen_cnt++;
      end else begin
        overflow_seen = 1'b1;  // kept but not stored
      end
    end
    w.value          = v;
    w.any_repeat     = repeat_seen;
    w.store_overflow = overflow_seen;
    w.set_done       = last;
    if (last) begin
      seen_cnt      = 0;
      repeat_seen   = 1'b0;
      overflow_seen = 1'b0;
    end
    return w;
  endfunction

  // sends one word; waits for the handshake, then records its expectation
  task automatic send_word(logic [SDR_VALUE_W-1:0] v, bit last, bit typed = 1'b0,
                           bit t_keep = 1'b0, bit t_rep = 1'b0, bit t_ovf = 1'b0);
    int          gap;
    dedup_word_t want;
    if ($urandom_range(0, 39) == 0) in_no_idle = !in_no_idle;
    // no gaps while the receiver holds off, so the chain fills up
    gap = (in_no_idle || hold_request) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = dedup_predict(v, last);
    if (typed) begin
      want.keep           = t_keep;
      want.any_repeat     = t_rep;
      want.store_overflow = t_ovf;
    end
    pending_words.push_back(want);
    words_sent++;
  endtask

  // sender pause until every expected word is back
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  function automatic logic [SDR_VALUE_W-1:0] pick_value(const ref logic [SDR_VALUE_W-1:0] vals[$]);
    logic [SDR_VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = (vals.size() != 0) ? vals[$urandom_range(0, vals.size() - 1)] : $urandom;
      4: begin
        case ($urandom_range(0, 4))
          0: v = 32'h0000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h8000_0000;
          3: v = 32'h7FFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      5, 6: v = $urandom_range(0, 7);  // small pool: repeats within and across sets
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // builds one set of the given kind and sends it, end mark on the last word
  task automatic send_set(int kind);
    logic [SDR_VALUE_W-1:0] vals[$];
    int                     n_distinct;
    int                     n;
    case (kind)
      KIND_SINGLE: vals.push_back(pick_value(vals));
      KIND_FULL, KIND_OVERFLOW: begin
        n_distinct = SDR_STORE_DEPTH;
        if (kind == KIND_OVERFLOW) n_distinct += $urandom_range(1, 6);
        for (int i = 0; i < n_distinct; i++) vals.push_back($urandom);
        // a stored value repeats (dropped); the last distinct value repeats (kept only when past the store)
        vals.push_back(vals[$urandom_range(0, SDR_STORE_DEPTH - 1)]);
        vals.push_back(vals[n_distinct - 1]);
        vals.push_back(vals[$urandom_range(0, n_distinct - 1)]);
      end
      default: begin
        n = $urandom_range(2, 16);
        for (int i = 0; i < n; i++) vals.push_back(pick_value(vals));
      end
    endcase
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
  endtask

  function automatic void compare_field(string name, logic [SDR_VALUE_W-1:0] want,
                                        logic [SDR_VALUE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // output monitor: checks each accepted word against the oldest expectation
  always @(posedge clk) begin
    dedup_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected output word %h (last %b)", out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        compare_field("echo_value", want.value, out_tdata[31:0]);
        compare_field("keep", 32'(want.keep), 32'(out_tdata[32]));
        compare_field("any_repeat", 32'(want.any_repeat), 32'(out_tdata[33]));
        compare_field("store_overflow", 32'(want.store_overflow), 32'(out_tdata[34]));
        compare_field("pad", '0, 32'(out_tdata[SDR_OUT_DATA_W-1:35]));
        compare_field("set_done", 32'(want.set_done), 32'(out_tlast));
        words_checked++;
        if (!out_tdata[32]) drops_seen++;
        if (out_tlast) begin
          sets_seen++;
          if (out_tdata[33]) sets_repeat++;
          if (out_tdata[34]) sets_overflow++;
        end
      end
    end
  end

  // watchdog: nothing moving on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls per word, bursts of no stall, one long hold-off on request
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        holds_done++;
      end else begin
        if ($urandom_range(0, 39) == 0) out_no_idle = !out_no_idle;
        stall = out_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // main sequence
  initial begin
    int  r;
    int  random_start;
    bit  hold_issued;
    bit  mid_drain;
    hold_issued = 1'b0;
    mid_drain   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    for (int i = 0; i < DIR_ROWS; i++)
      send_word(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].keep, dir_rows[i].any_repeat, dir_rows[i].store_overflow);
    drain_outputs();

    // random part: store exactly full first, then overflow, then a mix
    random_start = words_sent;
    send_set(KIND_FULL);
    send_set(KIND_OVERFLOW);
    while (words_sent - random_start < RANDOM_WORDS) begin
      if (!hold_issued && words_sent - random_start >= 400) begin
        hold_request = 1'b1;
        hold_issued  = 1'b1;
      end
      if (!mid_drain && words_sent - random_start >= 900) begin
        drain_outputs();
        mid_drain = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 3)       send_set(KIND_OVERFLOW);
      else if (r < 5)  send_set(KIND_FULL);
      else if (r < 15) send_set(KIND_SINGLE);
      else             send_set(KIND_SHORT);
    end
    in_tvalid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d words sent, %0d checked, %0d dropped as repeats; %0d receiver hold-off(s)",
             words_sent, words_checked, drops_seen, holds_done);
    $display("%0d sets closed: %0d with a repeat, %0d past store capacity",
             sets_seen, sets_repeat, sets_overflow);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
